FILE: rtl/aupd_pkg.sv
// Shared widths, types and register codes for the Adam parameter update block.
`timescale 1ns / 1ps
package aupd_pkg;

  // Fraction bits of the weight, gradient and moment data words.
  localparam int DATA_FRAC_BITS = 24;

  localparam int DATA_W   = 32;
  localparam int RECIP_W  = 40;                       // Q12.28 bias correction
  localparam int POW_W    = 33;                       // Q1.32 running power
  localparam int RECIP_FRAC = 28;
  localparam int G2_W     = 2 * DATA_W + 1 - DATA_FRAC_BITS;
  localparam int VP_W     = POW_W + G2_W;
  localparam int VHAT_W   = DATA_W + RECIP_W - RECIP_FRAC;
  localparam int NUM_W    = DATA_W + VHAT_W;
  localparam int RAD_W    = VHAT_W + 64 - DATA_FRAC_BITS;
  localparam int ROOT_W   = (RAD_W + 1) / 2;
  localparam int T_W      = 2 * ROOT_W + 1;
  localparam int DEN_W    = ROOT_W + 1;
  localparam int QCAP_BITS = 35;
  localparam int REM_W    = DEN_W + QCAP_BITS;
  localparam int W1_W     = DATA_W + 2;
  localparam int WF_W     = QCAP_BITS + 3;

  localparam logic [QCAP_BITS-1:0] Q_MAX = '1;
  localparam logic [RECIP_W-1:0] RECIP_MAX = '1;
  localparam logic [RECIP_W-1:0] RECIP_ONE = RECIP_W'(64'd1 << RECIP_FRAC);
  localparam logic [POW_W-1:0] POW_ONE = POW_W'(64'd1 << 32);
  localparam logic signed [WF_W-1:0] W_MAX = WF_W'(64'sd2147483647);
  localparam logic signed [WF_W-1:0] W_MIN = WF_W'(-64'sd2147483648);

  // Configuration register indexes.
  localparam logic [2:0] REG_LEARNING_RATE  = 3'd0;
  localparam logic [2:0] REG_MOMENTUM_DECAY = 3'd1;
  localparam logic [2:0] REG_VARIANCE_DECAY = 3'd2;
  localparam logic [2:0] REG_EPSILON        = 3'd3;
  localparam logic [2:0] REG_DECAY_COEF     = 3'd4;

  // Request codes.
  localparam logic REQ_START = 1'b0;
  localparam logic REQ_ELEM  = 1'b1;

  typedef struct packed {
    logic [DATA_W-1:0] lr;
    logic [DATA_W-1:0] b1;
    logic [DATA_W-1:0] b2;
    logic [DATA_W-1:0] eps;
    logic [DATA_W-1:0] wd;
  } cfg_t;

  typedef struct packed {
    logic [RECIP_W-1:0] mrec;
    logic [RECIP_W-1:0] vrec;
  } recip_t;

  // Per-element results that ride along with the square root and divide.
  typedef struct packed {
    logic signed [W1_W-1:0] w1;
    logic               neg;
    logic [DATA_W-1:0]  mn;
    logic [DATA_W-1:0]  vn;
    logic               sat;
  } side_t;

endpackage

FILE: rtl/aupd_step_unit.sv
// Step sequencer: advances the decay powers and divides out the bias corrections.
`timescale 1ns / 1ps
module aupd_step_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [aupd_pkg::DATA_W-1:0] momentum_decay,
  input  logic [aupd_pkg::DATA_W-1:0] variance_decay,
  output aupd_pkg::recip_t           recip,
  output logic                       busy
);

  localparam int NR_W = 61;
  localparam int DS_W = aupd_pkg::POW_W + aupd_pkg::RECIP_W - 1;
  localparam int CK_W = DS_W + 1;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_MUL   = 4'b0010,
    ST_CHECK = 4'b0100,
    ST_DIV   = 4'b1000
  } state_t;

  state_t state, state_next;

  logic [aupd_pkg::POW_W-1:0] mpow, vpow;
  logic [NR_W-1:0] mrem, vrem;
  logic [DS_W-1:0] mdiv, vdiv;
  logic [aupd_pkg::RECIP_W-1:0] mq, vq;
  logic mcap, vcap;
  logic [5:0] cnt;

  logic [64:0] mprod, vprod;
  logic [aupd_pkg::POW_W-1:0] mbc, vbc;
  logic [NR_W-1:0] mnum, vnum;
  logic mcap_c, vcap_c, mge, vge;
  logic [aupd_pkg::RECIP_W-1:0] mq_next, vq_next;

  always_comb begin
    mprod = 65'(mpow) * 65'(momentum_decay) + 65'(64'd1 << 31);
    vprod = 65'(vpow) * 65'(variance_decay) + 65'(64'd1 << 31);
    mbc = aupd_pkg::POW_ONE - mpow;
    vbc = aupd_pkg::POW_ONE - vpow;
    mnum = NR_W'(64'd1 << 60) + NR_W'(mbc >> 1);
    vnum = NR_W'(64'd1 << 60) + NR_W'(vbc >> 1);
    mcap_c = CK_W'(mnum) >= {mbc, aupd_pkg::RECIP_W'(0)};
    vcap_c = CK_W'(vnum) >= {vbc, aupd_pkg::RECIP_W'(0)};
    mge = DS_W'(mrem) >= mdiv;
    vge = DS_W'(vrem) >= vdiv;
    mq_next = {mq[aupd_pkg::RECIP_W-2:0], mge};
    vq_next = {vq[aupd_pkg::RECIP_W-2:0], vge};
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (start) state_next = ST_MUL;
      ST_MUL:   state_next = ST_CHECK;
      ST_CHECK: state_next = ST_DIV;
      ST_DIV:   if (cnt == 6'd0) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      mpow  <= aupd_pkg::POW_ONE;
      vpow  <= aupd_pkg::POW_ONE;
      recip <= '{mrec: aupd_pkg::RECIP_ONE, vrec: aupd_pkg::RECIP_ONE};
    end else begin
      state <= state_next;
      case (state)
        ST_MUL: begin
          mpow <= mprod[64:32];
          vpow <= vprod[64:32];
        end
        ST_DIV: begin
          if (cnt == 6'd0) begin
            recip.mrec <= mcap ? aupd_pkg::RECIP_MAX : mq_next;
            recip.vrec <= vcap ? aupd_pkg::RECIP_MAX : vq_next;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_CHECK: begin
        mrem <= mnum;
        vrem <= vnum;
        mdiv <= {mbc, (aupd_pkg::RECIP_W - 1)'(0)};
        vdiv <= {vbc, (aupd_pkg::RECIP_W - 1)'(0)};
        mcap <= mcap_c;
        vcap <= vcap_c;
        mq   <= '0;
        vq   <= '0;
        cnt  <= 6'(aupd_pkg::RECIP_W - 1);
      end
      ST_DIV: begin
        if (mge) mrem <= NR_W'(DS_W'(mrem) - mdiv);
        if (vge) vrem <= NR_W'(DS_W'(vrem) - vdiv);
        mdiv <= mdiv >> 1;
        vdiv <= vdiv >> 1;
        mq   <= mq_next;
        vq   <= vq_next;
        cnt  <= cnt - 6'd1;
      end
      default: ;
    endcase
  end

  assign busy = (state != ST_IDLE);

endmodule

FILE: rtl/aupd_front.sv
// Six-stage arithmetic front end: moments, corrections and the divide numerator.
`timescale 1ns / 1ps
module aupd_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              elem_valid,
  input  logic signed [aupd_pkg::DATA_W-1:0] weight_in,
  input  logic signed [aupd_pkg::DATA_W-1:0] gradient,
  input  logic signed [aupd_pkg::DATA_W-1:0] moment_in,
  input  logic [aupd_pkg::DATA_W-1:0]        variance_in,
  input  aupd_pkg::cfg_t                    cfg,
  input  aupd_pkg::recip_t                  recip,
  output logic                              valid,
  output logic [aupd_pkg::VHAT_W-1:0]        vhat,
  output logic [aupd_pkg::NUM_W-1:0]         num,
  output aupd_pkg::side_t                   side
);

  localparam int F = aupd_pkg::DATA_FRAC_BITS;
  localparam int RF = aupd_pkg::RECIP_FRAC;
  localparam int MP_W = aupd_pkg::DATA_W + aupd_pkg::RECIP_W;

  // Wide products are split into two partial products on the high and low slices of
  // one operand and summed in the following stage.
  localparam int LO_W = 20;
  localparam int ML_W = 22;
  localparam int VP2H_W = 33 + aupd_pkg::G2_W - LO_W;
  localparam int VP2L_W = 33 + LO_W;
  localparam int RPH_W = aupd_pkg::DATA_W + aupd_pkg::RECIP_W - LO_W;
  localparam int RPL_W = aupd_pkg::DATA_W + LO_W;
  localparam int NH_W = aupd_pkg::DATA_W + aupd_pkg::VHAT_W - ML_W;
  localparam int NL_W = aupd_pkg::DATA_W + ML_W;

  logic [5:0] vld;

  // Stage 1: first moment products, gradient square, decay product.
  logic signed [32:0] b1s;
  logic signed [33:0] omb1s;
  logic signed [64:0] ma_c;
  logic signed [65:0] mb_c;
  logic [31:0] gmag;
  logic [63:0] gsq_c, dr_c;
  logic signed [64:0] s1_ma;
  logic signed [65:0] s1_mb;
  logic [63:0] s1_gsq, s1_dr;
  logic signed [31:0] s1_w;
  logic [31:0] s1_v;
  aupd_pkg::recip_t s1_rec;

  always_comb begin
    b1s   = $signed({1'b0, cfg.b1});
    omb1s = $signed({1'b0, aupd_pkg::POW_ONE - {1'b0, cfg.b1}});
    ma_c  = b1s * moment_in;
    mb_c  = omb1s * gradient;
    gmag  = gradient[31] ? 32'(-gradient) : 32'(gradient);
    gsq_c = 64'(gmag) * 64'(gmag);
    dr_c  = 64'(cfg.lr) * 64'(cfg.wd);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_ma  <= ma_c;
      s1_mb  <= mb_c;
      s1_gsq <= gsq_c;
      s1_dr  <= dr_c;
      s1_w   <= weight_in;
      s1_v   <= variance_in;
      s1_rec <= recip;
    end
  end

  // Stage 2: round the new moment, the squared gradient and the decay factor.
  logic signed [66:0] msum;
  logic [64:0] gsum, dsum;
  logic signed [31:0] s2_mn, s2_w;
  logic [aupd_pkg::G2_W-1:0] s2_g2;
  logic [31:0] s2_dec, s2_v;
  aupd_pkg::recip_t s2_rec;

  always_comb begin
    msum = 67'(s1_ma) + 67'(s1_mb) + 67'sh8000_0000;
    gsum = 65'(s1_gsq) + (65'd1 << (F - 1));
    dsum = 65'(s1_dr) + 65'h8000_0000;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_mn  <= msum[63:32];
      s2_g2  <= gsum[64:F];
      s2_dec <= dsum[63:32];
      s2_w   <= s1_w;
      s2_v   <= s1_v;
      s2_rec <= s1_rec;
    end
  end

  // Stage 3: second moment products, partial products of the corrected
  // first moment, weight decay.
  logic [32:0] omb2;
  logic [31:0] mmag;
  logic [63:0] s3_vp1;
  logic [VP2H_W-1:0] s3_vp2h;
  logic [VP2L_W-1:0] s3_vp2l;
  logic [RPH_W-1:0] s3_mph;
  logic [RPL_W-1:0] s3_mpl;
  logic signed [64:0] s3_wdp;
  logic signed [31:0] s3_mn, s3_w;
  logic [aupd_pkg::RECIP_W-1:0] s3_vrec;

  always_comb begin
    omb2 = aupd_pkg::POW_ONE - {1'b0, cfg.b2};
    mmag = s2_mn[31] ? 32'(-s2_mn) : 32'(s2_mn);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_vp1  <= 64'(cfg.b2) * 64'(s2_v);
      s3_vp2h <= VP2H_W'(omb2) * VP2H_W'(s2_g2[aupd_pkg::G2_W-1:LO_W]);
      s3_vp2l <= VP2L_W'(omb2) * VP2L_W'(s2_g2[LO_W-1:0]);
      s3_mph  <= RPH_W'(mmag) * RPH_W'(s2_rec.mrec[aupd_pkg::RECIP_W-1:LO_W]);
      s3_mpl  <= RPL_W'(mmag) * RPL_W'(s2_rec.mrec[LO_W-1:0]);
      s3_wdp  <= s2_w * $signed({1'b0, s2_dec});
      s3_mn   <= s2_mn;
      s3_w    <= s2_w;
      s3_vrec <= s2_rec.vrec;
    end
  end

  // Stage 4: new second moment with clipping, mhat, decayed weight.
  logic [aupd_pkg::VP_W:0] vacc;
  logic [MP_W:0] hsum;
  logic signed [65:0] wsum;
  logic vclip;
  logic signed [aupd_pkg::W1_W-1:0] w1_c;
  aupd_pkg::side_t s4_side;
  logic [aupd_pkg::VHAT_W-1:0] s4_mhat;
  logic [aupd_pkg::RECIP_W-1:0] s4_vrec;

  always_comb begin
    vacc  = (aupd_pkg::VP_W + 1)'(s3_vp1)
            + ((aupd_pkg::VP_W + 1)'(s3_vp2h) << LO_W)
            + (aupd_pkg::VP_W + 1)'(s3_vp2l)
            + (aupd_pkg::VP_W + 1)'(64'h8000_0000);
    vclip = |vacc[aupd_pkg::VP_W:64];
    hsum  = ((MP_W + 1)'(s3_mph) << LO_W) + (MP_W + 1)'(s3_mpl)
            + (MP_W + 1)'(64'd1 << (RF - 1));
    wsum  = 66'(s3_wdp) + 66'sh8000_0000;
    w1_c  = aupd_pkg::W1_W'(s3_w) - aupd_pkg::W1_W'($signed(wsum[64:32]));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_side.w1  <= w1_c;
      s4_side.neg <= s3_mn[31];
      s4_side.mn  <= s3_mn;
      s4_side.vn  <= vclip ? '1 : vacc[63:32];
      s4_side.sat <= vclip;
      s4_mhat     <= hsum[RF +: aupd_pkg::VHAT_W];
      s4_vrec     <= s3_vrec;
    end
  end

  // Stage 5: partial products of the corrected second moment and numerator.
  logic [RPH_W-1:0] s5_vhph;
  logic [RPL_W-1:0] s5_vhpl;
  logic [NH_W-1:0] s5_numh;
  logic [NL_W-1:0] s5_numl;
  aupd_pkg::side_t s5_side;

  always_ff @(posedge clk) begin
    if (en) begin
      s5_vhph <= RPH_W'(s4_side.vn) * RPH_W'(s4_vrec[aupd_pkg::RECIP_W-1:LO_W]);
      s5_vhpl <= RPL_W'(s4_side.vn) * RPL_W'(s4_vrec[LO_W-1:0]);
      s5_numh <= NH_W'(cfg.lr) * NH_W'(s4_mhat[aupd_pkg::VHAT_W-1:ML_W]);
      s5_numl <= NL_W'(cfg.lr) * NL_W'(s4_mhat[ML_W-1:0]);
      s5_side <= s4_side;
    end
  end

  // Stage 6: sum the partial products and round vhat.
  logic [MP_W:0] vhsum;
  logic [aupd_pkg::NUM_W-1:0] nsum;

  assign vhsum = ((MP_W + 1)'(s5_vhph) << LO_W) + (MP_W + 1)'(s5_vhpl)
                 + (MP_W + 1)'(64'd1 << (RF - 1));
  assign nsum  = (aupd_pkg::NUM_W'(s5_numh) << ML_W) + aupd_pkg::NUM_W'(s5_numl);

  always_ff @(posedge clk) begin
    if (en) begin
      vhat <= vhsum[RF +: aupd_pkg::VHAT_W];
      num  <= nsum;
      side <= s5_side;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[4:0], elem_valid};
    end
  end

  assign valid = vld[5];

endmodule

FILE: rtl/aupd_sqrt_pipe.sv
// Pipelined integer square root, one root bit per stage.
`timescale 1ns / 1ps
module aupd_sqrt_pipe (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_vld,
  input  logic [aupd_pkg::VHAT_W-1:0]    vhat,
  input  logic [aupd_pkg::NUM_W-1:0]     num_in,
  input  aupd_pkg::side_t               side_in,
  output logic                          out_vld,
  output logic [aupd_pkg::ROOT_W-1:0]    root,
  output logic [aupd_pkg::NUM_W-1:0]     num_out,
  output aupd_pkg::side_t               side_out
);

  localparam int N = aupd_pkg::ROOT_W;
  localparam int TW = aupd_pkg::T_W;

  logic                       vld_q  [N+1];
  logic [TW-1:0]              rem_q  [N+1];
  logic [N-1:0]               root_q [N+1];
  logic [aupd_pkg::NUM_W-1:0] num_q  [N+1];
  aupd_pkg::side_t            side_q [N+1];

  assign vld_q[0]  = in_vld;
  assign rem_q[0]  = TW'(vhat) << (aupd_pkg::RAD_W - aupd_pkg::VHAT_W);
  assign root_q[0] = '0;
  assign num_q[0]  = num_in;
  assign side_q[0] = side_in;

  for (genvar k = 0; k < N; k++) begin : g_stage
    localparam int B = N - 1 - k;
    logic [TW-1:0] trial;
    logic fits;

    assign trial = (TW'(root_q[k]) << (B + 1)) + (TW'(1) << (2 * B));
    assign fits  = rem_q[k] >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k+1]  <= fits ? rem_q[k] - trial : rem_q[k];
        root_q[k+1] <= root_q[k] | (N'(fits) << B);
        num_q[k+1]  <= num_q[k];
        side_q[k+1] <= side_q[k];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[k+1] <= 1'b0;
      end else if (en) begin
        vld_q[k+1] <= vld_q[k];
      end
    end
  end

  assign out_vld  = vld_q[N];
  assign root     = root_q[N];
  assign num_out  = num_q[N];
  assign side_out = side_q[N];

endmodule

FILE: rtl/aupd_div_pipe.sv
// Pipelined rounded divide of the step numerator by the denominator, capped.
`timescale 1ns / 1ps
module aupd_div_pipe (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_vld,
  input  logic [aupd_pkg::ROOT_W-1:0]    root,
  input  logic [aupd_pkg::NUM_W-1:0]     num_in,
  input  aupd_pkg::side_t               side_in,
  input  logic [aupd_pkg::DATA_W-1:0]    eps,
  output logic                          out_vld,
  output logic [aupd_pkg::QCAP_BITS-1:0] quot,
  output aupd_pkg::side_t               side_out
);

  localparam int N  = aupd_pkg::QCAP_BITS;
  localparam int RW = aupd_pkg::REM_W;

  // Denominator stage.
  logic                        a_vld;
  logic [aupd_pkg::DEN_W-1:0]  a_den;
  logic [aupd_pkg::NUM_W-1:0]  a_num;
  aupd_pkg::side_t             a_side;

  always_ff @(posedge clk) begin
    if (en) begin
      a_den  <= aupd_pkg::DEN_W'(root) + aupd_pkg::DEN_W'(eps);
      a_num  <= num_in;
      a_side <= side_in;
    end
  end

  // Rounding offset and overflow check; a zero denominator lands in the cap
  // case unless the numerator is zero too.
  logic [RW-1:0] rsum;
  logic over, den_zero;

  always_comb begin
    rsum     = RW'(a_num) + RW'(a_den >> 1);
    den_zero = (a_den == '0);
    over     = rsum >= (RW'(a_den) << N);
  end

  logic                 vld_q   [N+1];
  logic [RW-1:0]        rem_q   [N+1];
  logic [RW-1:0]        den_q   [N+1];
  logic [N-1:0]         q_q     [N+1];
  logic                 fix_q   [N+1];
  logic [N-1:0]         fval_q  [N+1];
  aupd_pkg::side_t      side_q  [N+1];

  always_ff @(posedge clk) begin
    if (en) begin
      rem_q[0]  <= rsum;
      den_q[0]  <= RW'(a_den);
      q_q[0]    <= '0;
      fix_q[0]  <= over;
      fval_q[0] <= (den_zero && a_num == '0) ? '0 : aupd_pkg::Q_MAX;
      side_q[0] <= a_side;
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_stage
    localparam int B = N - 1 - k;
    logic [RW-1:0] trial;
    logic fits;

    assign trial = den_q[k] << B;
    assign fits  = rem_q[k] >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k+1]  <= fits ? rem_q[k] - trial : rem_q[k];
        q_q[k+1]    <= q_q[k] | (N'(fits) << B);
        den_q[k+1]  <= den_q[k];
        fix_q[k+1]  <= fix_q[k];
        fval_q[k+1] <= fval_q[k];
        side_q[k+1] <= side_q[k];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[k+1] <= 1'b0;
      end else if (en) begin
        vld_q[k+1] <= vld_q[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld    <= 1'b0;
      vld_q[0] <= 1'b0;
    end else if (en) begin
      a_vld    <= in_vld;
      vld_q[0] <= a_vld;
    end
  end

  assign out_vld  = vld_q[N];
  assign quot     = fix_q[N] ? fval_q[N] : q_q[N];
  assign side_out = side_q[N];

endmodule

FILE: rtl/adam_param_update_core.sv
// Top level of the fixed-point AdamW parameter update pipeline.
// Pipeline: an element passes 86 register stages from the edge that takes its transfer
// to its valid result (6 front, 42 square root, 37 divide, 1 output register).
// Throughput: one element per cycle while out_ready does not stall the output; a start
// transfer holds in_ready low while the sequencer divides out the two bias corrections.
// Reset (rst, synchronous) clears all valid bits and the sequencer and reloads the config.
`timescale 1ns / 1ps
module adam_param_update_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               req_type,
  input  logic signed [aupd_pkg::DATA_W-1:0]  weight_in,
  input  logic signed [aupd_pkg::DATA_W-1:0]  gradient,
  input  logic signed [aupd_pkg::DATA_W-1:0]  moment_in,
  input  logic [aupd_pkg::DATA_W-1:0]         variance_in,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [aupd_pkg::DATA_W-1:0]  weight_out,
  output logic signed [aupd_pkg::DATA_W-1:0]  moment_out,
  output logic [aupd_pkg::DATA_W-1:0]         variance_out,
  output logic                               saturated,
  input  logic                               cfg_write,
  input  logic [2:0]                         cfg_index,
  input  logic [aupd_pkg::DATA_W-1:0]         cfg_data
);

  // The whole element pipeline advances together. It moves whenever the
  // output register is empty or its result is being taken in this cycle, so
  // bubbles simply travel along with their cleared valid bits.
  logic en;
  logic accept;
  logic step_busy;

  assign en       = !out_valid || out_ready;
  assign in_ready = en && !step_busy;
  assign accept   = in_valid && in_ready;

  // Configuration registers; writes to unused indexes are dropped.
  aupd_pkg::cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.lr  <= 32'd4294967;
      cfg.b1  <= 32'd3865470566;
      cfg.b2  <= 32'd4290672329;
      cfg.eps <= 32'd43;
      cfg.wd  <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        aupd_pkg::REG_LEARNING_RATE:  cfg.lr  <= cfg_data;
        aupd_pkg::REG_MOMENTUM_DECAY: cfg.b1  <= cfg_data;
        aupd_pkg::REG_VARIANCE_DECAY: cfg.b2  <= cfg_data;
        aupd_pkg::REG_EPSILON:        cfg.eps <= cfg_data;
        aupd_pkg::REG_DECAY_COEF:     cfg.wd  <= cfg_data;
        default: ;
      endcase
    end
  end

  // A start transfer kicks off the sequencer. Elements sample the bias
  // corrections as they enter, so the ones already in flight keep the values
  // of their own step.
  aupd_pkg::recip_t recip;
  logic start_go, elem_go;

  assign start_go = accept && (req_type == aupd_pkg::REQ_START);
  assign elem_go  = accept && (req_type == aupd_pkg::REQ_ELEM);

  aupd_step_unit u_step (
    .clk            (clk),
    .rst            (rst),
    .start          (start_go),
    .momentum_decay (cfg.b1),
    .variance_decay (cfg.b2),
    .recip          (recip),
    .busy           (step_busy)
  );

  logic                       f_vld;
  logic [aupd_pkg::VHAT_W-1:0] f_vhat;
  logic [aupd_pkg::NUM_W-1:0]  f_num;
  aupd_pkg::side_t            f_side;

  aupd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .elem_valid  (elem_go),
    .weight_in   (weight_in),
    .gradient    (gradient),
    .moment_in   (moment_in),
    .variance_in (variance_in),
    .cfg         (cfg),
    .recip       (recip),
    .valid       (f_vld),
    .vhat        (f_vhat),
    .num         (f_num),
    .side        (f_side)
  );

  logic                       s_vld;
  logic [aupd_pkg::ROOT_W-1:0] s_root;
  logic [aupd_pkg::NUM_W-1:0]  s_num;
  aupd_pkg::side_t            s_side;

  aupd_sqrt_pipe u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (f_vld),
    .vhat     (f_vhat),
    .num_in   (f_num),
    .side_in  (f_side),
    .out_vld  (s_vld),
    .root     (s_root),
    .num_out  (s_num),
    .side_out (s_side)
  );

  logic                          d_vld;
  logic [aupd_pkg::QCAP_BITS-1:0] d_quot;
  aupd_pkg::side_t               d_side;

  aupd_div_pipe u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (s_vld),
    .root     (s_root),
    .num_in   (s_num),
    .side_in  (s_side),
    .eps      (cfg.eps),
    .out_vld  (d_vld),
    .quot     (d_quot),
    .side_out (d_side)
  );

  // Final stage: apply the step against the sign of the first moment and
  // clip the weight to the signed 32-bit range.
  logic signed [aupd_pkg::WF_W-1:0] w1x, qx, w2;
  logic wclip_hi, wclip_lo;

  always_comb begin
    w1x = aupd_pkg::WF_W'(d_side.w1);
    qx  = $signed(aupd_pkg::WF_W'(d_quot));
    w2  = d_side.neg ? w1x + qx : w1x - qx;
    wclip_hi = w2 > aupd_pkg::W_MAX;
    wclip_lo = w2 < aupd_pkg::W_MIN;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      weight_out   <= wclip_hi ? aupd_pkg::DATA_W'(aupd_pkg::W_MAX) :
                      wclip_lo ? aupd_pkg::DATA_W'(aupd_pkg::W_MIN) :
                      aupd_pkg::DATA_W'(w2);
      moment_out   <= d_side.mn;
      variance_out <= d_side.vn;
      saturated    <= d_side.sat || wclip_hi || wclip_lo;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= d_vld;
    end
  end

  // A start transfer always hands work to the sequencer.
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start_go |=> step_busy)
    else $error("start transfer did not engage the step sequencer");

  // The output register only fills from a valid item at the end of the divider.
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(d_vld))
    else $error("output became valid without a finished element");

  // No element enters while the bias corrections are being recomputed.
  a_no_elem_busy: assert property (@(posedge clk) disable iff (rst)
    step_busy |-> !elem_go)
    else $error("element taken while step sequencer busy");

endmodule
